// ----- sv/gga_pkg.sv -----
// ---------------------------------------------------------------------------
// gga_pkg - shared types and constants for the GGA field extractor
// Holds the header text, scan phase codes, the front-to-back queue entry
// and small decode helpers.
// ---------------------------------------------------------------------------
package gga_pkg;

  localparam int unsigned HDR_LEN       = 6;
  localparam int unsigned COMMA_SAT     = 8;
  localparam int unsigned QUEUE_DEPTH   = 4;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;

  // scan phase codes
  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_INSIDE = 2'd1;
  localparam logic [1:0] PH_CLOSED = 2'd2;

  // field tags
  localparam logic [1:0] TAG_LAT  = 2'd0;
  localparam logic [1:0] TAG_LON  = 2'd1;
  localparam logic [1:0] TAG_SATS = 2'd2;

  // item kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // one unit of work for the back end: an optional character item
  // followed by an optional verdict item
  typedef struct packed {
    logic       has_char;
    logic [1:0] tag;
    logic [7:0] char_value;
    logic       has_verdict;
    logic       fix_valid;
  } gga_entry_t;

  typedef struct packed {
    logic       push;
    gga_entry_t entry;
  } gga_push_t;

  typedef struct packed {
    logic       empty;
    gga_entry_t head;
  } gga_head_t;

  // header character at a match position
  function automatic logic [7:0] hdr_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h24; // '$'
      3'd1:    c = 8'h47; // 'G'
      3'd2:    c = 8'h4E; // 'N'
      3'd3:    c = 8'h47; // 'G'
      3'd4:    c = 8'h47; // 'G'
      3'd5:    c = 8'h41; // 'A'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // seen-flag bit for a comma field index, zero when not tracked
  function automatic logic [4:0] field_bit(input logic [3:0] f);
    logic [4:0] b;
    case (f)
      4'd2:    b = 5'b00001;
      4'd3:    b = 5'b00010;
      4'd4:    b = 5'b00100;
      4'd5:    b = 5'b01000;
      4'd7:    b = 5'b10000;
      default: b = 5'b00000;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/gga_if.sv -----
// ---------------------------------------------------------------------------
// gga_if - valid/ready channels of the GGA field extractor
// Input channel carries received bytes, output channel carries result items.
// ---------------------------------------------------------------------------
interface gga_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface gga_out_if;
  logic       valid;
  logic       ready;
  logic       item_kind;
  logic [1:0] field_tag;
  logic [7:0] char_value;
  logic       fix_valid;
  logic       last_result;

  modport source (output valid, output item_kind, output field_tag, output char_value,
                  output fix_valid, output last_result, input ready);
  modport sink   (input valid, input item_kind, input field_tag, input char_value,
                  input fix_valid, input last_result, output ready);
endinterface

// ----- sv/gga_front.sv -----
// ---------------------------------------------------------------------------
// gga_front - byte classifier of the GGA field extractor
// Matches the header, counts commas, tracks non-empty fields and pushes one
// queue entry for every byte that yields a character or a verdict.
// ---------------------------------------------------------------------------
module gga_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  output logic               ready,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_buffer,
  input  logic               full,
  output gga_pkg::gga_push_t wr
);

  logic [1:0] scan_phase, scan_phase_next;
  logic [2:0] header_match_count, header_match_count_next;
  logic [3:0] comma_count, comma_count_next;
  logic [4:0] field_seen_flags, field_seen_flags_next;
  logic       accept;
  logic [2:0] m;
  logic       emit_char;
  logic [1:0] tag;

  assign ready  = !full;
  assign accept = valid && ready;

  // classify the byte and work out the next scan state
  always_comb begin
    scan_phase_next         = scan_phase;
    header_match_count_next = header_match_count;
    comma_count_next        = comma_count;
    field_seen_flags_next   = field_seen_flags;
    emit_char               = 1'b0;
    tag                     = gga_pkg::TAG_LAT;
    m                       = 3'd0;
    case (scan_phase)
      gga_pkg::PH_SEARCH: begin
        m = (header_match_count >= 3'(gga_pkg::HDR_LEN)) ? 3'd0 : header_match_count;
        if (rx_byte == gga_pkg::hdr_char(m)) begin
          m = m + 3'd1;
        end else begin
          m = (rx_byte == gga_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
        end
        if (m >= 3'(gga_pkg::HDR_LEN)) begin
          scan_phase_next       = gga_pkg::PH_INSIDE;
          comma_count_next      = 4'd0;
          field_seen_flags_next = 5'd0;
          m                     = 3'd0;
        end
        header_match_count_next = m;
      end
      gga_pkg::PH_INSIDE: begin
        if (rx_byte == gga_pkg::CH_NEWLINE) begin
          scan_phase_next = gga_pkg::PH_CLOSED;
        end else if (rx_byte == gga_pkg::CH_COMMA) begin
          if (comma_count < 4'(gga_pkg::COMMA_SAT)) comma_count_next = comma_count + 4'd1;
        end else begin
          field_seen_flags_next = field_seen_flags | gga_pkg::field_bit(comma_count);
          case (comma_count)
            4'd2: begin
              emit_char = 1'b1;
              tag       = gga_pkg::TAG_LAT;
            end
            4'd4: begin
              emit_char = 1'b1;
              tag       = gga_pkg::TAG_LON;
            end
            4'd7: begin
              emit_char = 1'b1;
              tag       = gga_pkg::TAG_SATS;
            end
            default: emit_char = 1'b0;
          endcase
        end
      end
      default: begin
        // closed sentence: ignore bytes until the buffer ends
      end
    endcase
  end

  // build the queue entry
  always_comb begin
    wr.entry.has_char    = emit_char;
    wr.entry.tag         = tag;
    wr.entry.char_value  = rx_byte;
    wr.entry.has_verdict = end_of_buffer;
    wr.entry.fix_valid   = (scan_phase_next != gga_pkg::PH_SEARCH) &&
                           (field_seen_flags_next == 5'h1F);
    wr.push              = accept && (emit_char || end_of_buffer);
  end

  // advance scan state; return to reset values after the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_phase         <= gga_pkg::PH_SEARCH;
      header_match_count <= 3'd0;
      comma_count        <= 4'd0;
      field_seen_flags   <= 5'd0;
    end else if (accept) begin
      if (end_of_buffer) begin
        scan_phase         <= gga_pkg::PH_SEARCH;
        header_match_count <= 3'd0;
        comma_count        <= 4'd0;
        field_seen_flags   <= 5'd0;
      end else begin
        scan_phase         <= scan_phase_next;
        header_match_count <= header_match_count_next;
        comma_count        <= comma_count_next;
        field_seen_flags   <= field_seen_flags_next;
      end
    end
  end

  a_buffer_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> scan_phase == gga_pkg::PH_SEARCH && comma_count == 4'd0 &&
                                field_seen_flags == 5'd0 && header_match_count == 3'd0)
    else $error("scan state not cleared after buffer end");

  a_comma_saturates: assert property (@(posedge clk) disable iff (rst)
    comma_count <= 4'(gga_pkg::COMMA_SAT))
    else $error("comma count above saturation");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !wr.push)
    else $error("entry pushed into full queue");

endmodule

// ----- sv/gga_queue.sv -----
// ---------------------------------------------------------------------------
// gga_queue - entry queue between front and back of the GGA extractor
// Small circular buffer of work entries with a fill count.
// ---------------------------------------------------------------------------
module gga_queue #(
  parameter int unsigned DEPTH = gga_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  gga_pkg::gga_push_t wr,
  output logic               full,
  input  logic               pop,
  output gga_pkg::gga_head_t rd
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gga_pkg::gga_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd.empty = (count == '0);
  assign rd.head  = mem[rd_ptr];
  assign do_push  = wr.push && !full;
  assign do_pop   = pop && !rd.empty;

  // store entries
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr.entry;
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

endmodule

// ----- sv/gga_back.sv -----
// ---------------------------------------------------------------------------
// gga_back - result emitter of the GGA field extractor
// Turns queue entries into result items: a character item, a verdict item,
// or both in that order, through a registered output stage.
// ---------------------------------------------------------------------------
module gga_back (
  input  logic               clk,
  input  logic               rst,
  input  gga_pkg::gga_head_t rd,
  output logic               pop,
  output logic               valid,
  input  logic               ready,
  output logic               item_kind,
  output logic [1:0]         field_tag,
  output logic [7:0]         char_value,
  output logic               fix_valid,
  output logic               last_result
);

  logic char_done;
  logic load;
  logic take_char;

  assign load      = !valid || ready;
  assign take_char = rd.head.has_char && !char_done;
  // pop once the entry's last item goes out
  assign pop       = load && !rd.empty && !(take_char && rd.head.has_verdict);

  // output valid and character-sent flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      char_done <= 1'b0;
    end else if (load) begin
      valid <= !rd.empty;
      if (!rd.empty) char_done <= take_char && rd.head.has_verdict;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load && !rd.empty) begin
      if (take_char) begin
        item_kind   <= gga_pkg::KIND_CHAR;
        field_tag   <= rd.head.tag;
        char_value  <= rd.head.char_value;
        fix_valid   <= 1'b0;
        last_result <= 1'b0;
      end else begin
        item_kind   <= gga_pkg::KIND_VERDICT;
        field_tag   <= gga_pkg::TAG_LAT;
        char_value  <= 8'd0;
        fix_valid   <= rd.head.fix_valid;
        last_result <= 1'b1;
      end
    end
  end

  a_split_holds_head: assert property (@(posedge clk) disable iff (rst)
    char_done |-> !rd.empty && rd.head.has_verdict)
    else $error("split entry lost from queue head");

  a_verdict_clean: assert property (@(posedge clk) disable iff (rst)
    valid && item_kind == gga_pkg::KIND_VERDICT |-> last_result && char_value == 8'd0)
    else $error("verdict item carries character data");

endmodule

// ----- sv/nmea_gga_field_extractor.sv -----
// ---------------------------------------------------------------------------
// nmea_gga_field_extractor - GGA sentence field extractor, top level
// Bytes of a receive buffer enter on in_ch, one per transfer, the last one
// flagged by end_of_buffer. After the first "$GNGGA" header the characters
// of latitude, longitude and satellite-count fields leave on out_ch as
// tagged character items; the final byte adds a verdict item (fix_valid,
// last_result set) and the parser returns to header search.
// Throughput: one byte per cycle while the entry queue is not full. A byte
// produces zero, one or two items; a final byte that also carries a field
// character yields a character item followed by its verdict item.
// An item's entry is written into the queue at the input transfer edge and
// loads the output register once it is at the queue head and the output
// register is free; a verdict that follows a character item of the same
// byte is loaded after that character item.
// The entry queue (QUEUE_DEPTH entries) decouples classifier and emitter:
// in_ch.ready drops only while the queue is full, so bytes keep flowing
// while out_ch is stalled until the queue fills. Bytes that yield no item
// never occupy the queue.
// Reset (rst, synchronous): scan state returns to header search, queue
// empties, and out_ch.valid drops.
// ---------------------------------------------------------------------------
module nmea_gga_field_extractor #(
  parameter int unsigned QUEUE_DEPTH = gga_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  gga_in_if.sink    in_ch,
  gga_out_if.source out_ch
);

  gga_pkg::gga_push_t wr;
  gga_pkg::gga_head_t rd;
  logic               full;
  logic               pop;

  // classify bytes
  gga_front u_front (
    .clk           (clk),
    .rst           (rst),
    .valid         (in_ch.valid),
    .ready         (in_ch.ready),
    .rx_byte       (in_ch.rx_byte),
    .end_of_buffer (in_ch.end_of_buffer),
    .full          (full),
    .wr            (wr)
  );

  // hold pending work
  gga_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (full),
    .pop  (pop),
    .rd   (rd)
  );

  // emit result items
  gga_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd          (rd),
    .pop         (pop),
    .valid       (out_ch.valid),
    .ready       (out_ch.ready),
    .item_kind   (out_ch.item_kind),
    .field_tag   (out_ch.field_tag),
    .char_value  (out_ch.char_value),
    .fix_valid   (out_ch.fix_valid),
    .last_result (out_ch.last_result)
  );

endmodule

// ----- tb/tb_nmea_gga_field_extractor.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_nmea_gga_field_extractor - self-checking bench for the GGA extractor
// Feeds receive buffers byte by byte through the input channel and checks
// every item on the output channel against a sentence parser kept in the
// bench. A few hand-built buffers come first. Random buffers follow: mostly
// GGA sentences with random field contents, plus broken headers, cut-off
// sentences and noise. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_nmea_gga_field_extractor;

  localparam int    PLAN_BYTES = 730;
  localparam int    IDLE_LIMIT = 2000;
  localparam int    MAX_PRINTS = 40;
  localparam string GGA_HEADER = "$GNGGA";

  // comma-field positions that the parser tracks
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_EW   = 4'd5;
  localparam logic [3:0] FLD_SATS = 4'd7;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       eob;
  } rx_item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] tag;
    logic [7:0] ch;
    logic       fix;
    logic       closes;
  } gga_item_t;

  logic clk;
  logic rst;

  gga_in_if  in_ch ();
  gga_out_if out_ch ();

  nmea_gga_field_extractor u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // byte plan and expected output items
  rx_item_t   byte_plan[$];
  logic [7:0] frame[$];
  gga_item_t  gga_items_due[$];

  // parser state of the bench
  logic [1:0] sent_phase;
  logic [2:0] hdr_matched;
  logic [3:0] comma_cnt;
  logic [4:0] fields_filled;

  int bytes_planned = 0;
  int buffers_planned = 0;
  int bytes_issued = 0;
  int bytes_taken = 0;
  int items_taken = 0;
  int items_acked = 0;
  int verdicts_seen = 0;
  int fixes_seen = 0;
  int chars_seen = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  bit in_busy = 1'b0;
  int in_wait = 0;
  int in_run = 0;
  int in_style = 0;
  int out_wait = 0;
  int out_run = 0;
  int out_style = 0;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // print one mismatch line and count it
  task automatic report_mismatch(input string what);
    if (fail_count < MAX_PRINTS) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    fail_count++;
  endtask

  // wait length per transfer, in stretches of calm, light or heavy idling
  function automatic int next_wait(inout int run_left, inout int style);
    if (run_left == 0) begin
      run_left = $urandom_range(8, 48);
      style = $urandom_range(0, 2);
    end
    run_left--;
    case (style)
      0:       return 0;
      1:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 16);
    endcase
  endfunction

  // random byte biased toward the characters the parser reacts to
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return gga_pkg::CH_DOLLAR;
      1:       return gga_pkg::CH_COMMA;
      2:       return gga_pkg::CH_NEWLINE;
      3:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // field content: digits mostly, any byte but comma or newline sometimes
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    if ($urandom_range(0, 2) != 0) begin
      c = 8'h30 + 8'($urandom_range(0, 9));
    end else begin
      do c = 8'($urandom_range(0, 255));
      while (c == gga_pkg::CH_COMMA || c == gga_pkg::CH_NEWLINE);
    end
    return c;
  endfunction

  // append one byte to the current buffer
  task automatic add_byte(input logic [7:0] b);
    frame.insert(frame.size(), b);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // move the current buffer into the plan, flagging its final byte
  task automatic close_frame();
    rx_item_t it;
    for (int i = 0; i < frame.size(); i++) begin
      it.rx_byte = frame[i];
      it.eob = (i == frame.size() - 1);
      byte_plan.insert(byte_plan.size(), it);
    end
    bytes_planned += frame.size();
    if (frame.size() != 0) buffers_planned++;
    frame.delete();
  endtask

  task automatic push_char(input logic [1:0] tag, input logic [7:0] b);
    gga_item_t it;
    it.kind = gga_pkg::KIND_CHAR;
    it.tag = tag;
    it.ch = b;
    it.fix = 1'b0;
    it.closes = 1'b0;
    gga_items_due.insert(gga_items_due.size(), it);
  endtask

  // advance the bench parser by one byte and queue the items it yields
  task automatic parse_gga_byte(input logic [7:0] b, input logic eob);
    logic [2:0] m;
    logic [4:0] hit;
    gga_item_t  v;
    hit = '0;
    if (sent_phase == gga_pkg::PH_SEARCH) begin
      m = (hdr_matched >= gga_pkg::HDR_LEN) ? 3'd0 : hdr_matched;
      if (b == 8'(GGA_HEADER[m])) m = m + 3'd1;
      else m = (b == gga_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
      if (m >= gga_pkg::HDR_LEN) begin
        sent_phase = gga_pkg::PH_INSIDE;
        comma_cnt = '0;
        fields_filled = '0;
        m = '0;
      end
      hdr_matched = m;
    end else if (sent_phase == gga_pkg::PH_INSIDE) begin
      if (b == gga_pkg::CH_NEWLINE) begin
        sent_phase = gga_pkg::PH_CLOSED;
      end else if (b == gga_pkg::CH_COMMA) begin
        if (comma_cnt < gga_pkg::COMMA_SAT) comma_cnt = comma_cnt + 4'd1;
      end else begin
        case (comma_cnt)
          FLD_LAT: begin
            hit[0] = 1'b1;
            push_char(gga_pkg::TAG_LAT, b);
          end
          FLD_NS: hit[1] = 1'b1;
          FLD_LON: begin
            hit[2] = 1'b1;
            push_char(gga_pkg::TAG_LON, b);
          end
          FLD_EW: hit[3] = 1'b1;
          FLD_SATS: begin
            hit[4] = 1'b1;
            push_char(gga_pkg::TAG_SATS, b);
          end
          default: ;
        endcase
        fields_filled = fields_filled | hit;
      end
    end
    if (eob) begin
      v.kind = gga_pkg::KIND_VERDICT;
      v.tag = '0;
      v.ch = '0;
      v.fix = (sent_phase != gga_pkg::PH_SEARCH) && (&fields_filled);
      v.closes = 1'b1;
      gga_items_due.insert(gga_items_due.size(), v);
      sent_phase = gga_pkg::PH_SEARCH;
      hdr_matched = '0;
      comma_cnt = '0;
      fields_filled = '0;
    end
  endtask

  // drive bytes from the plan, with a drawn gap after each transfer
  always @(negedge clk) begin
    rx_item_t nxt;
    if (!rst) begin
      if (in_busy && bytes_taken == bytes_issued) in_busy = 1'b0;
      if (!in_busy) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (byte_plan.size() != 0) begin
          nxt = byte_plan.pop_front();
          in_busy = 1'b1;
          bytes_issued++;
          in_ch.rx_byte <= nxt.rx_byte;
          in_ch.end_of_buffer <= nxt.eob;
          in_wait = next_wait(in_run, in_style);
        end
      end
      in_ch.valid <= in_busy;
    end
  end

  // hold ready low for a drawn stall after each output transfer
  always @(negedge clk) begin
    if (!rst) begin
      if (items_taken != items_acked) begin
        items_acked = items_taken;
        out_wait = next_wait(out_run, out_style);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // check output transfers, then predict from input transfers
  always @(posedge clk) begin
    gga_item_t due;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        items_taken++;
        if (gga_items_due.size() == 0) begin
          report_mismatch($sformatf("item with nothing pending (kind %0b char %02h)",
                                    out_ch.item_kind, out_ch.char_value));
        end else begin
          due = gga_items_due.pop_front();
          if (out_ch.item_kind !== due.kind)
            report_mismatch($sformatf("item_kind %0b, want %0b", out_ch.item_kind, due.kind));
          if (out_ch.field_tag !== due.tag)
            report_mismatch($sformatf("field_tag %0d, want %0d", out_ch.field_tag, due.tag));
          if (out_ch.char_value !== due.ch)
            report_mismatch($sformatf("char_value %02h, want %02h", out_ch.char_value,
                                      due.ch));
          if (out_ch.fix_valid !== due.fix)
            report_mismatch($sformatf("fix_valid %0b, want %0b", out_ch.fix_valid, due.fix));
          if (out_ch.last_result !== due.closes)
            report_mismatch($sformatf("last_result %0b, want %0b", out_ch.last_result,
                                      due.closes));
          if (due.kind == gga_pkg::KIND_VERDICT) begin
            verdicts_seen++;
            if (due.fix) fixes_seen++;
          end else begin
            chars_seen++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        bytes_taken++;
        parse_gga_byte(in_ch.rx_byte, in_ch.end_of_buffer);
      end
    end
  end

  // end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d items still pending",
               IDLE_LIMIT, gga_items_due.size());
      $display("nmea_gga_field_extractor test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int pick;
    int commas;
    int len;
    int cut;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.rx_byte = '0;
    in_ch.end_of_buffer = 1'b0;
    out_ch.ready = 1'b0;
    sent_phase = gga_pkg::PH_SEARCH;
    hdr_matched = '0;
    comma_cnt = '0;
    fields_filled = '0;

    // zero byte, newline and doubled dollar before the header, a field of 8'hFF,
    // every tracked field filled, commas up to saturation, ignored byte after newline
    add_byte(8'h00);
    add_byte(gga_pkg::CH_NEWLINE);
    add_text("$");
    add_text(GGA_HEADER);
    add_text(",,");
    add_byte(8'hFF);
    add_text(",B,C,D,,E,");
    add_byte(gga_pkg::CH_NEWLINE);
    add_text("x");
    close_frame();
    // header complete on the final byte
    add_text(GGA_HEADER);
    close_frame();

    // random buffers
    while (bytes_planned < PLAN_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // noise only
        repeat ($urandom_range(1, 8)) add_byte(noise_byte());
      end else begin
        repeat ($urandom_range(0, 3)) add_byte(noise_byte());
        if (pick < 30) add_text(GGA_HEADER.substr(0, $urandom_range(0, 4)));
        add_text(GGA_HEADER);
        if (pick >= 30 && pick < 38) begin
          frame[frame.size() - 1 - $urandom_range(0, 5)] = noise_byte();
        end
        commas = $urandom_range(5, 11);
        for (int f = 0; f <= commas; f++) begin
          if (f > 0) add_byte(gga_pkg::CH_COMMA);
          len = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
          repeat (len) add_byte(field_char());
        end
        if ($urandom_range(0, 3) != 0) begin
          add_byte(gga_pkg::CH_NEWLINE);
          repeat ($urandom_range(0, 2)) add_byte(noise_byte());
        end
        // cut the sentence short now and then
        if ($urandom_range(0, 4) == 0) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end
      end
      close_frame();
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (bytes_taken == bytes_planned);
    while (gga_items_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d bytes in %0d buffers; checked %0d field characters and %0d verdicts",
             bytes_taken, buffers_planned, chars_seen, verdicts_seen);
    $display("of which %0d reported a valid fix; %0d mismatches", fixes_seen, fail_count);
    if (fail_count == 0) begin
      $display("nmea_gga_field_extractor test passed");
    end else begin
      $display("nmea_gga_field_extractor test failed");
    end
    $finish;
  end

endmodule
